>>> rtl/mec_pkg.sv
// shared types and constants for the mandelbrot escape count core
package mec_pkg;

    // fixed field widths
    localparam int COUNT_BITS = 16;
    localparam int INDEX_BITS = 12;
    localparam int COORD_BITS = 32;

    // config register indexes
    typedef enum logic [2:0] {
        CFG_MAX_ITER = 3'd0,
        CFG_LEFT     = 3'd1,
        CFG_BOTTOM   = 3'd2,
        CFG_COL_STEP = 3'd3,
        CFG_ROW_STEP = 3'd4
    } t_cfg_index;

    // one pixel request
    typedef struct packed {
        logic [INDEX_BITS-1:0] pixel_column;
        logic [INDEX_BITS-1:0] pixel_row;
    } t_in_beat;

    // one pixel result
    typedef struct packed {
        logic [COUNT_BITS-1:0] escape_count;
        logic [INDEX_BITS-1:0] result_column;
        logic [INDEX_BITS-1:0] result_row;
    } t_out_beat;

    // job handed from the front end to the iteration engine
    typedef struct packed {
        logic [INDEX_BITS-1:0]        col;
        logic [INDEX_BITS-1:0]        row;
        logic signed [COORD_BITS-1:0] cr;
        logic signed [COORD_BITS-1:0] ci;
    } t_job;

endpackage

>>> rtl/mandelbrot_escape_count_core.sv
// top level of the mandelbrot escape count core: config registers and wiring
//
// Usage:
//   Pixel channel: drive i_pixel (column, row) and raise start; the beat is
//   taken at a rising edge where start is high and busy is low. Up to three
//   pixels may be held ahead of the one being worked on.
//   Result channel: o_valid is high for exactly one cycle with o_result
//   (escape count plus the echoed column and row); results leave in the
//   order pixels arrived and the receiver cannot stall them.
//   Config port: i_cfg_we, i_cfg_index, i_cfg_data write one register per
//   cycle (0 limit, 1 left edge, 2 bottom edge, 3 column step, 4 row step);
//   other indexes are dropped. Write only while no pixel is in flight.
// Iteration: one pass of z = z*z + c is an update step, then a products step,
//   through one iteration unit, which works on one pixel at a time and takes
//   the next only once the last result has left. An escape count runs from
//   1 to the iteration limit, which is 256 after reset.
// Reset: synchronous, active low; clears the queue, the engine and loads the
//   default view and limit.
module mandelbrot_escape_count_core #(
    parameter int FRAC_BITS = 28
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  mec_pkg::t_in_beat                   i_pixel,
    output logic                                busy,
    output logic                                o_valid,
    output mec_pkg::t_out_beat                  o_result,
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_index,
    input  logic [mec_pkg::COORD_BITS-1:0]      i_cfg_data
);

    localparam logic [mec_pkg::COUNT_BITS-1:0]        RST_MAX_ITER = 16'd256;
    localparam logic signed [mec_pkg::COORD_BITS-1:0] RST_LEFT     = 32'shE000_0000;
    localparam logic signed [mec_pkg::COORD_BITS-1:0] RST_BOTTOM   = 32'shF000_0000;
    localparam logic signed [mec_pkg::COORD_BITS-1:0] RST_STEP     = 32'sd262144;

    logic [mec_pkg::COUNT_BITS-1:0]        r_max_iter;
    logic signed [mec_pkg::COORD_BITS-1:0] r_left;
    logic signed [mec_pkg::COORD_BITS-1:0] r_bottom;
    logic signed [mec_pkg::COORD_BITS-1:0] r_col_step;
    logic signed [mec_pkg::COORD_BITS-1:0] r_row_step;
    logic [mec_pkg::COUNT_BITS-1:0]        w_limit;

    logic          w_front_valid;
    mec_pkg::t_job w_front_job;
    logic          w_q_ready;
    logic          w_q_valid;
    mec_pkg::t_job w_q_job;
    logic          w_pop;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= RST_MAX_ITER;
            r_left     <= RST_LEFT;
            r_bottom   <= RST_BOTTOM;
            r_col_step <= RST_STEP;
            r_row_step <= RST_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mec_pkg::CFG_MAX_ITER: r_max_iter <= i_cfg_data[mec_pkg::COUNT_BITS-1:0];
                mec_pkg::CFG_LEFT:     r_left     <= i_cfg_data;
                mec_pkg::CFG_BOTTOM:   r_bottom   <= i_cfg_data;
                mec_pkg::CFG_COL_STEP: r_col_step <= i_cfg_data;
                mec_pkg::CFG_ROW_STEP: r_row_step <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // a zero limit behaves as one pass
    assign w_limit = (r_max_iter == '0) ? mec_pkg::COUNT_BITS'(1) : r_max_iter;

    // front end
    mec_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_beat      (i_pixel),
        .o_busy      (busy),
        .i_left      (r_left),
        .i_bottom    (r_bottom),
        .i_col_step  (r_col_step),
        .i_row_step  (r_row_step),
        .o_job_valid (w_front_valid),
        .o_job       (w_front_job),
        .i_job_ready (w_q_ready)
    );

    // job queue
    mec_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_front_valid & w_q_ready),
        .i_push_job (w_front_job),
        .o_ready    (w_q_ready),
        .i_pop      (w_pop),
        .o_valid    (w_q_valid),
        .o_job      (w_q_job)
    );

    // iteration engine
    mec_iter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_iter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_q_valid),
        .i_job       (w_q_job),
        .o_pop       (w_pop),
        .i_limit     (w_limit),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

`ifndef SYNTHESIS
    // every result reports at least one pass
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.escape_count != '0))
        else $error("escape count of zero delivered");

    // the engine passes through its load state between two results
    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("results on consecutive cycles");

    // busy only rises right after a pixel was taken in
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted pixel");
`endif

endmodule

>>> rtl/mec_front.sv
// front end: takes pixel beats and forms the point c in fixed point
module mec_front (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  mec_pkg::t_in_beat                       i_beat,
    output logic                                    o_busy,
    input  logic signed [mec_pkg::COORD_BITS-1:0]   i_left,
    input  logic signed [mec_pkg::COORD_BITS-1:0]   i_bottom,
    input  logic signed [mec_pkg::COORD_BITS-1:0]   i_col_step,
    input  logic signed [mec_pkg::COORD_BITS-1:0]   i_row_step,
    output logic                                    o_job_valid,
    output mec_pkg::t_job                           o_job,
    input  logic                                    i_job_ready
);

    localparam int IDX_S_W = mec_pkg::INDEX_BITS + 1;
    localparam int PROD_W  = IDX_S_W + mec_pkg::COORD_BITS;
    localparam int SUM_W   = PROD_W + 1;

    // saturate a wide coordinate to the signed 32-bit range
    function automatic logic signed [mec_pkg::COORD_BITS-1:0] sat_coord(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [mec_pkg::COORD_BITS-1:0] r;
        if (v[SUM_W-1:mec_pkg::COORD_BITS-1] != {(SUM_W-mec_pkg::COORD_BITS+1){v[SUM_W-1]}})
        begin
            r = v[SUM_W-1] ? {1'b1, {(mec_pkg::COORD_BITS-1){1'b0}}}
                           : {1'b0, {(mec_pkg::COORD_BITS-1){1'b1}}};
        end else begin
            r = v[mec_pkg::COORD_BITS-1:0];
        end
        return r;
    endfunction

    logic                          r_valid;
    mec_pkg::t_job                 r_job;
    logic                          w_accept;
    logic                          w_push;
    logic signed [IDX_S_W-1:0]     w_col_s;
    logic signed [IDX_S_W-1:0]     w_row_s;
    logic signed [PROD_W-1:0]      w_col_prod;
    logic signed [PROD_W-1:0]      w_row_prod;
    logic signed [SUM_W-1:0]       w_re_sum;
    logic signed [SUM_W-1:0]       w_im_sum;

    // handshake: stage holds one beat until the queue takes it
    assign w_push      = r_valid & i_job_ready;
    assign o_busy      = r_valid & ~i_job_ready;
    assign w_accept    = i_start & ~o_busy;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    // c = edge + index * step, one multiply per axis
    assign w_col_s    = $signed({1'b0, i_beat.pixel_column});
    assign w_row_s    = $signed({1'b0, i_beat.pixel_row});
    assign w_col_prod = w_col_s * i_col_step;
    assign w_row_prod = w_row_s * i_row_step;
    assign w_re_sum   = $signed({w_col_prod[PROD_W-1], w_col_prod})
                      + $signed({{(SUM_W-mec_pkg::COORD_BITS){i_left[mec_pkg::COORD_BITS-1]}},
                                 i_left});
    assign w_im_sum   = $signed({w_row_prod[PROD_W-1], w_row_prod})
                      + $signed({{(SUM_W-mec_pkg::COORD_BITS){i_bottom[mec_pkg::COORD_BITS-1]}},
                                 i_bottom});

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (w_push) begin
            r_valid <= 1'b0;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job.col <= i_beat.pixel_column;
            r_job.row <= i_beat.pixel_row;
            r_job.cr  <= sat_coord(w_re_sum);
            r_job.ci  <= sat_coord(w_im_sum);
        end
    end

endmodule

>>> rtl/mec_queue.sv
// two-entry job queue between the front end and the iteration engine
module mec_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mec_pkg::t_job i_push_job,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output mec_pkg::t_job o_job
);

    localparam int DEPTH  = 2;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    mec_pkg::t_job     r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;

    assign o_ready = (r_fill != FILL_W'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_job   = r_slot[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

>>> rtl/mec_iter.sv
// iteration engine: runs z = z*z + c until escape or the limit
module mec_iter #(
    parameter int FRAC_BITS = 28
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_job_valid,
    input  mec_pkg::t_job                      i_job,
    output logic                               o_pop,
    input  logic [mec_pkg::COUNT_BITS-1:0]     i_limit,
    output logic                               o_valid,
    output mec_pkg::t_out_beat                 o_result
);

    localparam int X_W    = FRAC_BITS + 4;
    localparam int MAG_W  = FRAC_BITS + 3;
    localparam int SQ_W   = FRAC_BITS + 3;
    localparam int PROD_W = 2 * MAG_W;
    localparam int SH_W   = PROD_W - FRAC_BITS;
    localparam int ACC_W  = ((X_W > mec_pkg::COORD_BITS) ? X_W : mec_pkg::COORD_BITS) + 2;

    localparam logic [SQ_W-1:0]         SQ_FOUR      = SQ_W'(1) << (FRAC_BITS + 2);
    localparam logic signed [X_W-1:0]   X_FOUR       = $signed(X_W'(1) << (FRAC_BITS + 2));
    localparam logic signed [X_W-1:0]   X_NEG_FOUR   = -X_FOUR;
    localparam logic signed [ACC_W-1:0] ACC_FOUR     = $signed(ACC_W'(1) << (FRAC_BITS + 2));
    localparam logic signed [ACC_W-1:0] ACC_NEG_FOUR = -ACC_FOUR;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_MUL
    } t_state;

    t_state                              r_state;
    logic                                r_valid;
    mec_pkg::t_out_beat                  r_result;
    logic [mec_pkg::INDEX_BITS-1:0]      r_col;
    logic [mec_pkg::INDEX_BITS-1:0]      r_row;
    logic signed [mec_pkg::COORD_BITS-1:0] r_cr;
    logic signed [mec_pkg::COORD_BITS-1:0] r_ci;
    logic signed [X_W-1:0]               r_x;
    logic signed [X_W-1:0]               r_y;
    logic [SQ_W-1:0]                     r_xx;
    logic [SQ_W-1:0]                     r_yy;
    logic signed [SQ_W-1:0]              r_xy;
    logic [mec_pkg::COUNT_BITS-1:0]      r_count;

    logic [X_W-1:0]          w_ax;
    logic [X_W-1:0]          w_ay;
    logic [PROD_W-1:0]       w_pxx;
    logic [PROD_W-1:0]       w_pyy;
    logic [PROD_W-1:0]       w_pxy;
    logic [SH_W-1:0]         w_sh_xx;
    logic [SH_W-1:0]         w_sh_yy;
    logic [SH_W-1:0]         w_sh_xy;
    logic [SQ_W-1:0]         w_sq_xx;
    logic [SQ_W-1:0]         w_sq_yy;
    logic [SQ_W-2:0]         w_mxy;
    logic signed [SQ_W-1:0]  w_xy;
    logic [SQ_W:0]           w_sum;
    logic                    w_esc;
    logic                    w_done;
    logic signed [ACC_W-1:0] w_nx;
    logic signed [ACC_W-1:0] w_ny;
    logic signed [X_W-1:0]   w_x_next;
    logic signed [X_W-1:0]   w_y_next;

    assign o_pop    = (r_state == S_IDLE) & i_job_valid;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // magnitudes and the three products of one pass
    assign w_ax    = r_x[X_W-1] ? X_W'(-r_x) : X_W'(r_x);
    assign w_ay    = r_y[X_W-1] ? X_W'(-r_y) : X_W'(r_y);
    assign w_pxx   = PROD_W'(w_ax[MAG_W-1:0]) * PROD_W'(w_ax[MAG_W-1:0]);
    assign w_pyy   = PROD_W'(w_ay[MAG_W-1:0]) * PROD_W'(w_ay[MAG_W-1:0]);
    assign w_pxy   = PROD_W'(w_ax[MAG_W-1:0]) * PROD_W'(w_ay[MAG_W-1:0]);
    assign w_sh_xx = w_pxx[PROD_W-1:FRAC_BITS];
    assign w_sh_yy = w_pyy[PROD_W-1:FRAC_BITS];
    assign w_sh_xy = w_pxy[PROD_W-1:FRAC_BITS];

    // squares pinned at 4.0: anything that large escapes anyway
    assign w_sq_xx = (|w_sh_xx[SH_W-1:FRAC_BITS+2]) ? SQ_FOUR
                                                     : {1'b0, w_sh_xx[FRAC_BITS+1:0]};
    assign w_sq_yy = (|w_sh_yy[SH_W-1:FRAC_BITS+2]) ? SQ_FOUR
                                                     : {1'b0, w_sh_yy[FRAC_BITS+1:0]};

    // cross term, only read while |z| < 2 so the low bits are exact
    assign w_mxy = w_sh_xy[FRAC_BITS+1:0];
    assign w_xy  = (r_x[X_W-1] ^ r_y[X_W-1]) ? -$signed({1'b0, w_mxy})
                                             : $signed({1'b0, w_mxy});

    // escape test on the last squares
    assign w_sum  = {1'b0, r_xx} + {1'b0, r_yy};
    assign w_esc  = |w_sum[SQ_W:FRAC_BITS+2];
    assign w_done = (r_count != '0) && ((r_count >= i_limit) || w_esc);

    // z update
    assign w_nx = $signed({{(ACC_W-SQ_W){1'b0}}, r_xx})
                - $signed({{(ACC_W-SQ_W){1'b0}}, r_yy})
                + $signed({{(ACC_W-mec_pkg::COORD_BITS){r_cr[mec_pkg::COORD_BITS-1]}}, r_cr});
    assign w_ny = $signed({{(ACC_W-SQ_W-1){r_xy[SQ_W-1]}}, r_xy, 1'b0})
                + $signed({{(ACC_W-mec_pkg::COORD_BITS){r_ci[mec_pkg::COORD_BITS-1]}}, r_ci});

    // clamp both parts to +-4.0
    always_comb begin
        priority if (w_nx > ACC_FOUR) begin
            w_x_next = X_FOUR;
        end else if (w_nx < ACC_NEG_FOUR) begin
            w_x_next = X_NEG_FOUR;
        end else begin
            w_x_next = w_nx[X_W-1:0];
        end
        priority if (w_ny > ACC_FOUR) begin
            w_y_next = X_FOUR;
        end else if (w_ny < ACC_NEG_FOUR) begin
            w_y_next = X_NEG_FOUR;
        end else begin
            w_y_next = w_ny[X_W-1:0];
        end
    end

    // sequencer: load, then alternate update and multiply passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_col   <= i_job.col;
                        r_row   <= i_job.row;
                        r_cr    <= i_job.cr;
                        r_ci    <= i_job.ci;
                        r_x     <= '0;
                        r_y     <= '0;
                        r_xx    <= '0;
                        r_yy    <= '0;
                        r_xy    <= '0;
                        r_count <= '0;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (w_done) begin
                        r_valid                <= 1'b1;
                        r_result.escape_count  <= r_count;
                        r_result.result_column <= r_col;
                        r_result.result_row    <= r_row;
                        r_state                <= S_IDLE;
                    end else begin
                        r_x     <= w_x_next;
                        r_y     <= w_y_next;
                        r_count <= r_count + mec_pkg::COUNT_BITS'(1);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_xx    <= w_sq_xx;
                    r_yy    <= w_sq_yy;
                    r_xy    <= w_xy;
                    r_state <= S_UPD;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> test/mandelbrot_escape_count_core_tb.sv
// self-checking testbench for the mandelbrot escape count core
`timescale 1ns / 1ps

module mandelbrot_escape_count_core_tb;

    localparam int FRAC_BITS    = 28;
    localparam int RANDOM_ITEMS = 900;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES  = 64;
    localparam int N_ROWS       = 44;
    // slowest correct run: the directed part (one pixel at the full 16-bit
    // limit) plus two deep phases of 30 pixels at up to 1024 passes and about
    // 900 pixels at up to 256 passes, each after a random gap, fits well under
    // the cap
    localparam int LIMIT_CYCLES = 3_000_000;

    localparam longint FOUR_Q  = 64'sd1 <<< (FRAC_BITS + 2);
    localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_MIN = -64'sh0000_0000_8000_0000;
    localparam logic [63:0] SAT_MAG = 64'h4000_0000_0000_0000;

    // indexes with no register behind them
    localparam logic [2:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CFG_SPARE_MID   = 3'd6;
    localparam logic [2:0] CFG_SPARE_LAST  = 3'd7;

    typedef enum logic {
        ROW_CONFIG,
        ROW_PIXEL
    } t_row_kind;

    // one directed step: a register write or a pixel; count 0 means predicted
    typedef struct packed {
        t_row_kind                      kind;
        logic [2:0]                     reg_index;
        logic [31:0]                    data;
        logic [mec_pkg::INDEX_BITS-1:0] col;
        logic [mec_pkg::INDEX_BITS-1:0] row;
        logic [mec_pkg::COUNT_BITS-1:0] count;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [N_ROWS] = '{
        // reset view: c = -2-1i, c = 0, far corners, c = -1 cycle, c = 1
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd0,    12'd0,    16'd1},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd2048, 12'd1024, 16'd256},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd4095, 12'd4095, 16'd1},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd4095, 12'd0,    16'd1},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd0,    12'd4095, 16'd1},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd1024, 12'd1024, 16'd256},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd3072, 12'd1024, 16'd0},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd1500, 12'd1700, 16'd0},
        // zero limit behaves as a limit of one
        '{ROW_CONFIG, mec_pkg::CFG_MAX_ITER, 32'h0,        12'd0,    12'd0,    16'd0},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd2048, 12'd1024, 16'd1},
        '{ROW_CONFIG, mec_pkg::CFG_MAX_ITER, 32'h1,        12'd0,    12'd0,    16'd0},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd2048, 12'd1024, 16'd1},
        // writes to unused indexes must leave the view alone
        '{ROW_CONFIG, mec_pkg::CFG_MAX_ITER, 32'd16,       12'd0,    12'd0,    16'd0},
        '{ROW_CONFIG, CFG_SPARE_FIRST,       32'h7FFFFFFF, 12'd0,    12'd0,    16'd0},
        '{ROW_CONFIG, CFG_SPARE_MID,         32'h7FFFFFFF, 12'd0,    12'd0,    16'd0},
        '{ROW_CONFIG, CFG_SPARE_LAST,        32'h7FFFFFFF, 12'd0,    12'd0,    16'd0},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd2048, 12'd1024, 16'd16},
        // largest limit on a point inside the set
        '{ROW_CONFIG, mec_pkg::CFG_MAX_ITER, 32'd65535,    12'd0,    12'd0,    16'd0},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd2048, 12'd1024, 16'd65535},
        // real part of c saturating high, then low
        '{ROW_CONFIG, mec_pkg::CFG_MAX_ITER, 32'd64,       12'd0,    12'd0,    16'd0},
        '{ROW_CONFIG, mec_pkg::CFG_LEFT,     32'h7FFFFFFF, 12'd0,    12'd0,    16'd0},
        '{ROW_CONFIG, mec_pkg::CFG_COL_STEP, 32'h7FFFFFFF, 12'd0,    12'd0,    16'd0},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd4095, 12'd1024, 16'd1},
        '{ROW_CONFIG, mec_pkg::CFG_LEFT,     32'h80000000, 12'd0,    12'd0,    16'd0},
        '{ROW_CONFIG, mec_pkg::CFG_COL_STEP, 32'h80000000, 12'd0,    12'd0,    16'd0},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd4095, 12'd1024, 16'd1},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd0,    12'd1024, 16'd1},
        // imaginary part of c at both extremes, real part zero
        '{ROW_CONFIG, mec_pkg::CFG_LEFT,     32'h0,        12'd0,    12'd0,    16'd0},
        '{ROW_CONFIG, mec_pkg::CFG_COL_STEP, 32'h0,        12'd0,    12'd0,    16'd0},
        '{ROW_CONFIG, mec_pkg::CFG_BOTTOM,   32'h80000000, 12'd0,    12'd0,    16'd0},
        '{ROW_CONFIG, mec_pkg::CFG_ROW_STEP, 32'h7FFFFFFF, 12'd0,    12'd0,    16'd0},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd0,    12'd0,    16'd1},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd0,    12'd4095, 16'd1},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd4095, 12'd1,    16'd0},
        // c = -2 exactly hits |z|^2 = 4 on the first pass
        '{ROW_CONFIG, mec_pkg::CFG_LEFT,     32'hE0000000, 12'd0,    12'd0,    16'd0},
        '{ROW_CONFIG, mec_pkg::CFG_BOTTOM,   32'h0,        12'd0,    12'd0,    16'd0},
        '{ROW_CONFIG, mec_pkg::CFG_ROW_STEP, 32'h0,        12'd0,    12'd0,    16'd0},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd777,  12'd3333, 16'd1},
        // cusp at 0.25 and just past it, then just left of -2
        '{ROW_CONFIG, mec_pkg::CFG_LEFT,     32'h04000000, 12'd0,    12'd0,    16'd0},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd0,    12'd0,    16'd0},
        '{ROW_CONFIG, mec_pkg::CFG_LEFT,     32'h04000001, 12'd0,    12'd0,    16'd0},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd0,    12'd0,    16'd0},
        '{ROW_CONFIG, mec_pkg::CFG_LEFT,     32'hDFFFFFFF, 12'd0,    12'd0,    16'd0},
        '{ROW_PIXEL,  mec_pkg::CFG_MAX_ITER, 32'h0,        12'd0,    12'd0,    16'd1}
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    mec_pkg::t_in_beat              i_pixel;
    logic                           busy;
    logic                           o_valid;
    mec_pkg::t_out_beat             o_result;
    logic                           i_cfg_we;
    logic [2:0]                     i_cfg_index;
    logic [mec_pkg::COORD_BITS-1:0] i_cfg_data;

    // register copies for prediction
    logic [15:0] max_iter_q;
    logic [31:0] left_edge_q;
    logic [31:0] bottom_edge_q;
    logic [31:0] column_step_q;
    logic [31:0] row_step_q;

    // count typed into the table for the pixel on the port, 0 when predicted
    logic [mec_pkg::COUNT_BITS-1:0] known_count;

    mec_pkg::t_out_beat results_due[$];
    int unsigned        error_count = 0;
    int unsigned        cycle_count = 0;
    int unsigned        burst_left;

    mandelbrot_escape_count_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_pixel     (i_pixel),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // fixed-point helpers: magnitudes, truncated products, clamps
    function automatic logic [63:0] magnitude_of(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] fx_mul_mag(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = prod >> FRAC_BITS;
        return (prod > {64'd0, SAT_MAG}) ? SAT_MAG : prod[63:0];
    endfunction

    function automatic longint fx_mul_signed(input longint a, input longint b);
        longint m;
        m = longint'(fx_mul_mag(magnitude_of(a), magnitude_of(b)));
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic longint clamp_to_four(input longint v);
        if (v > FOUR_Q) return FOUR_Q;
        if (v < -FOUR_Q) return -FOUR_Q;
        return v;
    endfunction

    function automatic longint clip_to_s32(input longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // escape-time iteration for one pixel under the current register copies
    function automatic logic [mec_pkg::COUNT_BITS-1:0] escape_count_of(
        input logic [mec_pkg::INDEX_BITS-1:0] col,
        input logic [mec_pkg::INDEX_BITS-1:0] row
    );
        longint cr, ci, x, y, xy, xx, yy;
        int unsigned limit, passes;
        cr = clip_to_s32(longint'($signed(left_edge_q))
                         + longint'(col) * longint'($signed(column_step_q)));
        ci = clip_to_s32(longint'($signed(bottom_edge_q))
                         + longint'(row) * longint'($signed(row_step_q)));
        limit = 32'(max_iter_q);
        passes = 0;
        x = 0;
        y = 0;
        xx = 0;
        yy = 0;
        do begin
            xy = fx_mul_signed(x, y);
            x = clamp_to_four(xx - yy + cr);
            y = clamp_to_four(2 * xy + ci);
            xx = longint'(fx_mul_mag(magnitude_of(x), magnitude_of(x)));
            yy = longint'(fx_mul_mag(magnitude_of(y), magnitude_of(y)));
            passes++;
        end while (passes < limit && xx + yy < FOUR_Q);
        return passes[mec_pkg::COUNT_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
    endtask

    // gap before the next pixel, with occasional back-to-back bursts
    function automatic int unsigned draw_gap();
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // present one pixel beat and wait until it is taken
    task automatic send_pixel(
        input logic [mec_pkg::INDEX_BITS-1:0] col,
        input logic [mec_pkg::INDEX_BITS-1:0] row,
        input logic [mec_pkg::COUNT_BITS-1:0] typed,
        input int unsigned                    gap
    );
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_pixel <= '{pixel_column: col, pixel_row: row};
        known_count <= typed;
        do @(posedge i_clk); while (busy);
    endtask

    // stop sending and let every pending result come out
    task automatic quiesce();
        start <= 1'b0;
        // let the scoreboard record the last accepted beat first
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write; the caller drops the write enable after a batch
    task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            mec_pkg::CFG_MAX_ITER: max_iter_q = value[15:0];
            mec_pkg::CFG_LEFT:     left_edge_q = value;
            mec_pkg::CFG_BOTTOM:   bottom_edge_q = value;
            mec_pkg::CFG_COL_STEP: column_step_q = value;
            mec_pkg::CFG_ROW_STEP: row_step_q = value;
            default: ;
        endcase
    endtask

    // result check first, then record the beat accepted at this edge
    always @(posedge i_clk) begin : scoreboard
        mec_pkg::t_out_beat want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with no pixel pending: count",
                                    longint'(o_result.escape_count), 0);
                end else begin
                    want = results_due.pop_front();
                    if (o_result.escape_count !== want.escape_count)
                        report_mismatch("escape_count", longint'(o_result.escape_count),
                                        longint'(want.escape_count));
                    if (o_result.result_column !== want.result_column)
                        report_mismatch("result_column", longint'(o_result.result_column),
                                        longint'(want.result_column));
                    if (o_result.result_row !== want.result_row)
                        report_mismatch("result_row", longint'(o_result.result_row),
                                        longint'(want.result_row));
                end
            end
            if (start && !busy) begin
                want.result_column = i_pixel.pixel_column;
                want.result_row = i_pixel.pixel_row;
                want.escape_count = (known_count != 0) ? known_count
                    : escape_count_of(i_pixel.pixel_column, i_pixel.pixel_row);
                results_due.push_back(want);
            end
        end
    end

    // run-length guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus: directed table, then randomly configured phases
    initial begin : stimulus
        bit          cfg_open;
        int unsigned sent;
        int unsigned sel;
        int unsigned view;
        int unsigned lim;
        int unsigned deep_phases;
        int unsigned phase_items;
        logic [31:0] left, bottom, col_step, row_step;

        cfg_open = 1'b0;
        sent = 0;
        deep_phases = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_pixel = '0;
        known_count = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = mec_pkg::CFG_MAX_ITER;
        i_cfg_data = '0;
        max_iter_q = 16'd256;
        left_edge_q = 32'hE0000000;
        bottom_edge_q = 32'hF0000000;
        column_step_q = 32'd262144;
        row_step_q = 32'd262144;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < N_ROWS; i++) begin
            if (DIRECTED_ROWS[i].kind == ROW_CONFIG) begin
                if (!cfg_open) quiesce();
                cfg_open = 1'b1;
                set_reg(DIRECTED_ROWS[i].reg_index, DIRECTED_ROWS[i].data);
            end else begin
                if (cfg_open) i_cfg_we <= 1'b0;
                cfg_open = 1'b0;
                send_pixel(DIRECTED_ROWS[i].col, DIRECTED_ROWS[i].row,
                           DIRECTED_ROWS[i].count, draw_gap());
            end
        end

        // random phases, each with a fresh limit and view
        while (sent < RANDOM_ITEMS) begin
            quiesce();
            sel = $urandom_range(0, 9);
            if (sel <= 1)
                lim = $urandom_range(0, 1);
            else if (sel <= 4)
                lim = $urandom_range(2, 32);
            else if (sel <= 6)
                lim = $urandom_range(33, 255);
            else if (sel <= 8 || deep_phases >= 2)
                lim = 256;
            else begin
                lim = $urandom_range(257, 1024);
                deep_phases++;
            end

            view = $urandom_range(0, 9);
            if (view <= 5) begin
                // whole-set view: real -2.5..-0.5 start, imaginary -1.5..0 start
                left = -$urandom_range(32'd134217728, 32'd671088640);
                bottom = -$urandom_range(32'd0, 32'd402653184);
                col_step = $urandom_range(32'd16384, 32'd262144);
                row_step = $urandom_range(32'd16384, 32'd262144);
            end else if (view <= 7) begin
                // deep zoom near the set
                left = -$urandom_range(32'd0, 32'd536870912);
                bottom = $urandom_range(32'd0, 32'd536870912) - 32'd268435456;
                col_step = $urandom_range(32'd1, 32'd4096);
                row_step = $urandom_range(32'd1, 32'd4096);
                if ($urandom_range(0, 1)) col_step = -col_step;
                if ($urandom_range(0, 1)) row_step = -row_step;
            end else begin
                // raw register noise
                left = $urandom;
                bottom = $urandom;
                col_step = $urandom;
                row_step = $urandom;
            end

            set_reg(mec_pkg::CFG_MAX_ITER, lim);
            set_reg(mec_pkg::CFG_LEFT, left);
            set_reg(mec_pkg::CFG_BOTTOM, bottom);
            set_reg(mec_pkg::CFG_COL_STEP, col_step);
            set_reg(mec_pkg::CFG_ROW_STEP, row_step);
            set_reg(3'($urandom_range(32'(CFG_SPARE_FIRST), 32'(CFG_SPARE_LAST))), $urandom);
            i_cfg_we <= 1'b0;

            phase_items = (lim > 256) ? 30 : 110;
            repeat (phase_items) begin
                send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                           '0, draw_gap());
                sent++;
            end
        end

        // drain and finish
        start <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
rtl/mec_pkg.sv
rtl/mec_front.sv
rtl/mec_queue.sv
rtl/mec_iter.sv
rtl/mandelbrot_escape_count_core.sv
test/mandelbrot_escape_count_core_tb.sv
